[design/mcpf_pkg.sv]
// Package for the multi-channel pipe FIFO: sizes, command and status codes,
// transaction payload structs and controller/datapath command types. No dependencies.
package mcpf_pkg;

  localparam int unsigned NumPipes   = 16;
  localparam int unsigned PipeDepth  = 512;
  localparam int unsigned MaxBurst   = 8;
  localparam int unsigned PipeW      = (NumPipes > 1) ? $clog2(NumPipes) : 1;
  localparam int unsigned PtrW       = $clog2(PipeDepth);
  localparam int unsigned FillW      = $clog2(PipeDepth + 1);
  localparam int unsigned AddrW      = PipeW + PtrW;
  localparam int unsigned StoreDepth = NumPipes * PipeDepth;
  localparam int unsigned BurstW     = 4;

  localparam logic [2:0] KindCreate  = 3'd0;
  localparam logic [2:0] KindWrite   = 3'd1;
  localparam logic [2:0] KindRead    = 3'd2;
  localparam logic [2:0] KindCloseRd = 3'd3;
  localparam logic [2:0] KindCloseWr = 3'd4;
  localparam logic [2:0] KindPoll    = 3'd5;

  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StWouldBlock = 3'd1;
  localparam logic [2:0] StEof        = 3'd2;
  localparam logic [2:0] StBroken     = 3'd3;
  localparam logic [2:0] StBad        = 3'd4;
  localparam logic [2:0] StNoneFree   = 3'd5;

  localparam logic [3:0] EvIn  = 4'd1;
  localparam logic [3:0] EvOut = 4'd2;
  localparam logic [3:0] EvErr = 4'd4;
  localparam logic [3:0] EvHup = 4'd8;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  pipe;
    logic [63:0] wdata;
    logic [3:0]  length;
    logic        writer_end;
    logic [3:0]  events;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] rdata;
    logic [3:0]  moved;
    logic [3:0]  new_pipe;
    logic [3:0]  occurred;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item, decide
    logic step_wr;   // write one byte
    logic step_rd;   // issue one byte read
    logic cap_rd;    // capture read data byte
    logic finish;    // commit pointers, form result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       do_wr;   // item needs byte writes
    logic       do_rd;   // item needs byte reads
    logic [3:0] count;   // bytes to move
  } dp_sts_t;

endpackage

[design/mcpf_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module mcpf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[design/mcpf_datapath.sv]
// Datapath: per-pipe flags and pointers, byte store, result formation.
// Depends on mcpf_pkg and mcpf_ram.
module mcpf_datapath import mcpf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output out_item_t res_o
);

  logic [NumPipes-1:0] used_q, rclosed_q, wclosed_q;
  logic [PtrW-1:0]     rptr_q [NumPipes];
  logic [PtrW-1:0]     wptr_q [NumPipes];
  logic [FillW-1:0]    fill_q [NumPipes];

  in_item_t        item_q;
  logic [PipeW-1:0] sel_q;
  logic [PtrW-1:0]  ptr_q;
  logic [3:0]       idx_q;
  logic [2:0]       status_q;
  logic [3:0]       count_q;
  logic [3:0]       occ_q;
  logic [3:0]       newp_q;
  logic             do_wr_q, do_rd_q;
  logic [63:0]      rdata_q;
  logic [3:0]       cap_idx_q;

  // decode of the incoming item against current state
  logic [PipeW-1:0] sel;
  logic             valid, used, rcl, wcl;
  logic [FillW-1:0] fill, room;
  logic [3:0]       len;
  logic             free_found;
  logic [PipeW-1:0] free_idx;
  logic [2:0]       st_d;
  logic [3:0]       cnt_d, occ_d, newp_d;
  logic             wr_d, rd_d;

  assign sel   = in_i.pipe[PipeW-1:0];
  assign valid = ({28'd0, in_i.pipe} < NumPipes);
  assign used  = used_q[sel];
  assign rcl   = rclosed_q[sel];
  assign wcl   = wclosed_q[sel];
  assign fill  = fill_q[sel];
  assign room  = FillW'(PipeDepth) - fill;
  assign len   = (in_i.length > 4'(MaxBurst)) ? 4'(MaxBurst) : in_i.length;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NumPipes - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = PipeW'(i);
      end
    end
  end

  always_comb begin
    logic [3:0] f;
    f      = '0;
    st_d   = StOk;
    cnt_d  = '0;
    occ_d  = '0;
    newp_d = '0;
    wr_d   = 1'b0;
    rd_d   = 1'b0;
    unique case (in_i.kind)
      KindCreate: begin
        if (free_found) newp_d = 4'(free_idx);
        else st_d = StNoneFree;
      end
      KindWrite: begin
        if (!valid || !used) st_d = StBad;
        else if (rcl) st_d = StBroken;
        else if (room == '0) st_d = StWouldBlock;
        else begin
          cnt_d = ({{(FillW-4){1'b0}}, len} < room) ? len : 4'(room);
          wr_d  = 1'b1;
        end
      end
      KindRead: begin
        if (!valid || !used) st_d = StBad;
        else if (fill != '0) begin
          cnt_d = ({{(FillW-4){1'b0}}, len} < fill) ? len : 4'(fill);
          rd_d  = 1'b1;
        end else if (wcl) st_d = StEof;
        else st_d = StWouldBlock;
      end
      KindCloseRd, KindCloseWr: begin
        if (!valid) st_d = StBad;
      end
      KindPoll: begin
        if (!valid || !used) st_d = StBad;
        else begin
          if (!in_i.writer_end) begin
            if (fill != '0) f = f | EvIn;
            if (wcl) f = f | EvIn | EvHup;
          end else begin
            if (fill < FillW'(PipeDepth) && !rcl) f = f | EvOut;
            if (rcl) f = f | EvErr | EvHup;
          end
          occ_d = f & in_i.events;
        end
      end
      default: st_d = StBad;
    endcase
  end

  // byte store
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [7:0]       ram_wdata, ram_rdata;
  logic [PtrW-1:0]  ptr_next;

  assign ptr_next  = (ptr_q == PtrW'(PipeDepth - 1)) ? '0 : ptr_q + 1'b1;
  assign ram_we    = cmd_i.step_wr;
  assign ram_addr  = {sel_q, ptr_q};
  assign ram_wdata = item_q.wdata[{idx_q[2:0], 3'b000} +: 8];

  mcpf_ram #(.Width(8), .Depth(StoreDepth)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // item registers and byte stepping
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q   <= in_i;
      sel_q    <= sel;
      status_q <= st_d;
      count_q  <= cnt_d;
      occ_q    <= occ_d;
      newp_q   <= newp_d;
      do_wr_q  <= wr_d;
      do_rd_q  <= rd_d;
      idx_q    <= '0;
      cap_idx_q <= '0;
      rdata_q  <= '0;
      ptr_q    <= wr_d ? wptr_q[sel] : rptr_q[sel];
    end else begin
      if (cmd_i.step_wr || cmd_i.step_rd) begin
        ptr_q <= ptr_next;
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.cap_rd) begin
        rdata_q[{cap_idx_q[2:0], 3'b000} +: 8] <= ram_rdata;
        cap_idx_q <= cap_idx_q + 1'b1;
      end
    end
  end

  // per-pipe state commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      rclosed_q <= '0;
      wclosed_q <= '0;
      for (int i = 0; i < NumPipes; i++) begin
        rptr_q[i] <= '0;
        wptr_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else if (cmd_i.finish) begin
      unique case (item_q.kind)
        KindCreate: begin
          if (status_q == StOk) begin
            used_q[newp_q[PipeW-1:0]]    <= 1'b1;
            rclosed_q[newp_q[PipeW-1:0]] <= 1'b0;
            wclosed_q[newp_q[PipeW-1:0]] <= 1'b0;
            rptr_q[newp_q[PipeW-1:0]]    <= '0;
            wptr_q[newp_q[PipeW-1:0]]    <= '0;
            fill_q[newp_q[PipeW-1:0]]    <= '0;
          end
        end
        KindWrite: begin
          if (do_wr_q) begin
            wptr_q[sel_q] <= ptr_q;
            fill_q[sel_q] <= fill_q[sel_q] + FillW'(count_q);
          end
        end
        KindRead: begin
          if (do_rd_q) begin
            rptr_q[sel_q] <= ptr_q;
            fill_q[sel_q] <= fill_q[sel_q] - FillW'(count_q);
          end
        end
        KindCloseRd: begin
          if (status_q == StOk) begin
            rclosed_q[sel_q] <= 1'b1;
            if (wclosed_q[sel_q]) used_q[sel_q] <= 1'b0;
          end
        end
        KindCloseWr: begin
          if (status_q == StOk) begin
            wclosed_q[sel_q] <= 1'b1;
            if (rclosed_q[sel_q]) used_q[sel_q] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign sts_o.do_wr = wr_d;
  assign sts_o.do_rd = rd_d;
  assign sts_o.count = cnt_d;

  assign res_o.status   = status_q;
  assign res_o.rdata    = rdata_q;
  assign res_o.moved    = count_q;
  assign res_o.new_pipe = newp_q;
  assign res_o.occurred = occ_q;

endmodule

[design/mcpf_ctrl.sv]
// Controller: sequences one command through decode, byte steps and commit.
// Depends on mcpf_pkg.
module mcpf_ctrl import mcpf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_WR, S_RD, S_RD_LAST, S_FIN, S_OUT
  } state_e;

  state_e     state_q;
  logic [3:0] left_q;
  logic       rd_cap_q;

  assign in_ready  = (state_q == S_IDLE);
  assign out_valid = (state_q == S_OUT);

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = (state_q == S_IDLE) && in_valid;
    cmd_o.step_wr = (state_q == S_WR) && (left_q != '0);
    cmd_o.step_rd = (state_q == S_RD) && (left_q != '0);
    cmd_o.cap_rd  = rd_cap_q;
    cmd_o.finish  = (state_q == S_FIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      left_q   <= '0;
      rd_cap_q <= 1'b0;
    end else begin
      rd_cap_q <= cmd_o.step_rd;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid) begin
            left_q <= sts_i.count;
            if (sts_i.do_wr) state_q <= S_WR;
            else if (sts_i.do_rd) state_q <= S_RD;
            else state_q <= S_FIN;
          end
        end
        S_WR: begin
          if (left_q == '0) state_q <= S_FIN;
          else left_q <= left_q - 1'b1;
        end
        S_RD: begin
          if (left_q == '0) state_q <= S_RD_LAST;
          else left_q <= left_q - 1'b1;
        end
        // spare cycle; the last read byte was captured on leaving S_RD
        S_RD_LAST: state_q <= S_FIN;
        S_FIN:     state_q <= S_OUT;
        S_OUT: begin
          if (out_ready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[design/multi_channel_pipe_fifo.sv]
// Top level of the multi-channel pipe FIFO: controller plus datapath.
// Depends on mcpf_pkg, mcpf_ctrl, mcpf_datapath.
//
//   channel  handshake                 payload
//   in       in_valid / in_ready       in_data_i  (in_item_t)
//   out      out_valid / out_ready     out_data_o (out_item_t)
//
// One command at a time: create, close, poll and failed commands go from decode
// straight to commit; a write steps one byte at a time through the store, a read
// likewise plus a spare state for the last byte (one store port, byte wide,
// registered read), then the result waits for out_ready.
// Reset clears all pipe flags, pointers and fill counts at once; the byte
// store is not cleared. A stalled result holds the block until taken.
module multi_channel_pipe_fifo import mcpf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data_i,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mcpf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mcpf_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_data_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (out_data_o)
  );

endmodule
